### rtl/fpmc_pkg.sv
// shared types, constants and helpers of the frustum plane mask culler
`default_nettype none

package fpmc_pkg;

	localparam int MAX_PLANES  = 32;
	localparam int COORD_WIDTH = 32;
	localparam int COORD_W     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int IDX_W       = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int COUNT_W     = $clog2(MAX_PLANES + 1);
	localparam int ACC_W       = 66;

	localparam logic [31:0] FULL_MASK = 32'hffff_ffff;

	// item actions
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_TEST = 2'd2;

	// visibility codes
	localparam logic [1:0] VIS_OUTSIDE = 2'd0;
	localparam logic [1:0] VIS_PARTIAL = 2'd1;
	localparam logic [1:0] VIS_INSIDE  = 2'd2;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] d;
	} plane_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic  load;
		logic  acc_en;
		axis_t axis;
	} mac_ctrl_t;

	typedef struct packed {
		logic above;
		logic below;
	} mac_status_t;

	// sign extension from the coordinate width
	function automatic logic signed [31:0] sext_coord(input logic [31:0] v);
		logic signed [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = (i < COORD_W) ? v[i] : v[COORD_W-1];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/fpmc_plane_store.sv
// plane stack memory, one write port and one registered read port
`default_nettype none

module fpmc_plane_store (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [fpmc_pkg::IDX_W-1:0] waddr,
	input  wire fpmc_pkg::plane_t          wdata,
	input  wire logic [fpmc_pkg::IDX_W-1:0] raddr,
	output fpmc_pkg::plane_t               rdata
);
	import fpmc_pkg::*;

	plane_t mem_q [MAX_PLANES];
	plane_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/fpmc_mac.sv
// shared multiply-accumulate unit with the radius compare
`default_nettype none

module fpmc_mac (
	input  wire logic               clk,
	input  wire fpmc_pkg::mac_ctrl_t ctrl,
	input  wire fpmc_pkg::plane_t   plane,
	input  wire logic signed [31:0] cx,
	input  wire logic signed [31:0] cy,
	input  wire logic signed [31:0] cz,
	input  wire logic [30:0]        radius,
	output fpmc_pkg::mac_status_t   status
);
	import fpmc_pkg::*;

	logic signed [31:0]      op_a;
	logic signed [31:0]      op_b;
	logic signed [63:0]      prod_full;
	logic signed [63:0]      prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] sum;
	logic signed [31:0]      d_sx;
	logic signed [ACC_W-1:0] d_ext;
	logic signed [ACC_W-1:0] r_pos;
	logic signed [ACC_W-1:0] r_neg;

	always_comb begin
		case (ctrl.axis)
			AXIS_X: begin
				op_a = sext_coord(plane.nx);
				op_b = cx;
			end
			AXIS_Y: begin
				op_a = sext_coord(plane.ny);
				op_b = cy;
			end
			AXIS_Z: begin
				op_a = sext_coord(plane.nz);
				op_b = cz;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_full = op_a * op_b;
	assign prod_ext  = {{(ACC_W-64){prod_q[63]}}, prod_q};

	// d widened to q34.32
	assign d_sx  = sext_coord(plane.d);
	assign d_ext = {{(ACC_W-48){d_sx[31]}}, d_sx, 16'd0};

	always_ff @(posedge clk) begin
		prod_q <= prod_full;
		if (ctrl.load) begin
			acc_q <= d_ext;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// final term folded in with the compare
	assign sum   = acc_q + prod_ext;
	assign r_pos = {{(ACC_W-47){1'b0}}, radius, 16'd0};
	assign r_neg = -r_pos;

	assign status.above = (sum > r_pos);
	assign status.below = (sum < r_neg);

endmodule

`default_nettype wire

### rtl/frustum_plane_mask_culler.sv
// frustum plane culler: plane stack, coherency mask and sphere test sequencer
// push, refused pop, empty test and unknown action strobe done in the cycle after transfer
// pop passes through S_POP (registered read of the plane store), then strobes done
// test: a masked plane takes only S_RD, a tested plane takes S_RD, S_MX, S_MY, S_MZ and S_FIN (read,
//   three products on the one shared 32x32 multiplier, add and compare), done strobed after the walk
// busy is high after a pop or non-empty test transfer until done; next transfer may land in the done cycle
// reset (arst_n low, asynchronous): plane count 0, mask all ones, no strobe; store contents undefined
`default_nettype none

module frustum_plane_mask_culler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] normal_x,
	input  wire logic signed [31:0] normal_y,
	input  wire logic signed [31:0] normal_z,
	input  wire logic signed [31:0] plane_offset,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic signed [31:0] center_z,
	input  wire logic [30:0]        radius,
	input  wire logic               clear_after,
	output logic                    done,
	output logic [1:0]              visibility,
	output logic                    accepted,
	output logic signed [31:0]      popped_normal_x,
	output logic signed [31:0]      popped_normal_y,
	output logic signed [31:0]      popped_normal_z,
	output logic signed [31:0]      popped_offset,
	output logic [31:0]             active_mask
);
	import fpmc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_MX   = 7'b0000100,
		S_MY   = 7'b0001000,
		S_MZ   = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_POP  = 7'b1000000
	} state_t;

	state_t state_q;

	// architectural state
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        mask_q;

	// walk state
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] inside_q;
	logic               clear_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] cz_q;
	logic [30:0]        radius_q;

	// result register
	logic               done_q;
	logic [1:0]         vis_q;
	logic               acc_q;
	plane_t             popped_q;

	// store and shared unit hookup
	plane_t             wdata;
	plane_t             rdata;
	logic               we;
	logic [IDX_W-1:0]   raddr;
	logic [COUNT_W-1:0] top;
	logic               full;
	logic               xfer;
	mac_ctrl_t          mac_ctrl;
	mac_status_t        mac_st;

	// end-of-walk decode
	logic               above_fin;
	logic               inc_inside;
	logic [COUNT_W-1:0] inside_next;
	logic [1:0]         vis_fin;

	assign busy = (state_q != S_IDLE);
	assign xfer = start && !busy;
	assign full = (count_q >= COUNT_W'(MAX_PLANES));
	assign top  = count_q - COUNT_W'(1);

	// push writes straight from the transfer
	assign we          = xfer && (action == ACT_PUSH) && !full;
	assign wdata.nx    = normal_x;
	assign wdata.ny    = normal_y;
	assign wdata.nz    = normal_z;
	assign wdata.d     = plane_offset;

	// idle reads the top entry for a pop, the walk reads the current plane
	assign raddr = (state_q == S_IDLE) ? top[IDX_W-1:0] : idx_q;

	fpmc_plane_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// the mx step loads d and takes the x product, my and mz fold in the earlier products
	always_comb begin
		mac_ctrl.load   = (state_q == S_MX);
		mac_ctrl.acc_en = (state_q == S_MY) || (state_q == S_MZ);
		if (state_q == S_MX) begin
			mac_ctrl.axis = AXIS_X;
		end else if (state_q == S_MY) begin
			mac_ctrl.axis = AXIS_Y;
		end else begin
			mac_ctrl.axis = AXIS_Z;
		end
	end

	fpmc_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.plane  (rdata),
		.cx     (cx_q),
		.cy     (cy_q),
		.cz     (cz_q),
		.radius (radius_q),
		.status (mac_st)
	);

	// a masked plane counts as inside, a tested plane only when wholly inside
	always_comb begin
		above_fin   = (state_q == S_FIN) && mac_st.above;
		inc_inside  = (state_q == S_RD) || ((state_q == S_FIN) && mac_st.below);
		inside_next = inside_q + COUNT_W'(inc_inside);
		if (above_fin) begin
			vis_fin = VIS_OUTSIDE;
		end else if (inside_next == count_q) begin
			vis_fin = VIS_INSIDE;
		end else begin
			vis_fin = VIS_PARTIAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mask_q  <= FULL_MASK;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (action)
							ACT_PUSH: begin
								if (!full) begin
									count_q <= count_q + COUNT_W'(1);
								end
							end
							ACT_POP: begin
								if (count_q != '0) begin
									count_q <= top;
									state_q <= S_POP;
								end else begin
									done_q <= 1'b1;
								end
							end
							ACT_TEST: begin
								if (count_q != '0) begin
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
						if (action != ACT_POP && !(action == ACT_TEST && count_q != '0)) begin
							done_q <= 1'b1;
						end
					end
				end
				S_RD: begin
					if (!mask_q[idx_q]) begin
						// plane already known inside, no arithmetic needed
						if (idx_q == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (clear_q) begin
								mask_q <= FULL_MASK;
							end
						end else begin
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_MX;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_MZ;
				S_MZ: state_q <= S_FIN;
				S_FIN: begin
					if (mac_st.below) begin
						mask_q[idx_q] <= 1'b0;
					end
					if (above_fin || idx_q == '0) begin
						// culled early or last plane done
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (clear_q) begin
							mask_q <= FULL_MASK;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_POP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk registers and result payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					clear_q  <= clear_after;
					cx_q     <= sext_coord(center_x);
					cy_q     <= sext_coord(center_y);
					cz_q     <= sext_coord(center_z);
					radius_q <= radius;
					idx_q    <= top[IDX_W-1:0];
					inside_q <= '0;
					vis_q    <= VIS_OUTSIDE;
					popped_q <= '0;
					case (action)
						ACT_PUSH: acc_q <= !full;
						ACT_POP:  acc_q <= 1'b0;
						ACT_TEST: acc_q <= 1'b1;
						default:  acc_q <= 1'b0;
					endcase
				end
			end
			S_RD: begin
				if (!mask_q[idx_q]) begin
					inside_q <= inside_next;
					if (idx_q == '0) begin
						vis_q <= vis_fin;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
			end
			S_FIN: begin
				inside_q <= inside_next;
				if (above_fin || idx_q == '0) begin
					vis_q <= vis_fin;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			S_POP: begin
				acc_q    <= 1'b1;
				popped_q <= rdata;
			end
			default: begin
			end
		endcase
	end

	assign done            = done_q;
	assign visibility      = vis_q;
	assign accepted        = acc_q;
	assign popped_normal_x = popped_q.nx;
	assign popped_normal_y = popped_q.ny;
	assign popped_normal_z = popped_q.nz;
	assign popped_offset   = popped_q.d;
	// the mask register already holds the value after the item while done is high
	assign active_mask     = mask_q;

endmodule

`default_nettype wire

### tb/sv/frustum_plane_mask_culler_tb.sv
// self-checking testbench of the frustum plane mask culler: stack, mask and sphere tests
`default_nettype none

module frustum_plane_mask_culler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpmc_pkg::*;

	// action code that the block ignores
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	// cycles with no transfer and no result before the run is given up
	localparam int IDLE_LIMIT = 5000;
	// quiet cycles after the last result, well above the longest test walk
	localparam int TAIL_CYCLES = 200;
	localparam int ITEM_TARGET = 2000;

	localparam logic signed [31:0] ONE   = 32'sh0001_0000;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] d;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        radius;
		logic               clear_after;
	} cull_item_t;

	typedef struct packed {
		logic [1:0]         vis;
		logic               acc;
		logic signed [31:0] pnx;
		logic signed [31:0] pny;
		logic signed [31:0] pnz;
		logic signed [31:0] pd;
		logic [31:0]        mask;
	} cull_outcome_t;

	// plane stack and coherency mask mirrored in the testbench, plus the outcomes still owed
	class culler_scoreboard;
		plane_t          planes [MAX_PLANES];
		int unsigned     depth;
		logic [31:0]     mask;
		cull_outcome_t   pending [$];
		int unsigned     mismatches;

		function new();
			depth      = 0;
			mask       = FULL_MASK;
			mismatches = 0;
		endfunction

		// sign extension from the coordinate width into the exact sum width
		function logic signed [69:0] widen(logic [31:0] v);
			logic signed [69:0] w;
			w = {{38{v[31]}}, v};
			if (COORD_W < 32) begin
				w = (w <<< (70 - COORD_W)) >>> (70 - COORD_W);
			end
			return w;
		endfunction

		function void note_item(cull_item_t it);
			cull_outcome_t      o;
			logic signed [69:0] r_q;
			logic signed [69:0] neg_r;
			logic signed [69:0] plane_dist;
			int unsigned        inside_cnt;
			bit                 culled;
			plane_t             p;
			o          = '0;
			inside_cnt = 0;
			culled     = 1'b0;
			case (it.action)
				ACT_PUSH: begin
					if (depth < MAX_PLANES) begin
						planes[depth] = '{it.nx, it.ny, it.nz, it.d};
						depth++;
						o.acc = 1'b1;
					end
				end
				ACT_POP: begin
					if (depth != 0) begin
						p     = planes[depth - 1];
						o.acc = 1'b1;
						o.pnx = p.nx;
						o.pny = p.ny;
						o.pnz = p.nz;
						o.pd  = p.d;
						depth--;
					end
				end
				ACT_TEST: begin
					o.acc = 1'b1;
					if (depth != 0) begin
						r_q   = {23'b0, it.radius, 16'b0};
						neg_r = -r_q;
						// highest plane first; a masked plane counts as inside untested
						for (int ip = int'(depth) - 1; ip >= 0; ip--) begin
							if (mask[ip]) begin
								p          = planes[ip];
								plane_dist = widen(p.nx) * widen(it.cx)
									+ widen(p.ny) * widen(it.cy)
									+ widen(p.nz) * widen(it.cz) + (widen(p.d) <<< 16);
								if (plane_dist > r_q) begin
									culled = 1'b1;
									break;
								end
								if (plane_dist < neg_r) begin
									mask[ip] = 1'b0;
									inside_cnt++;
								end
							end else begin
								inside_cnt++;
							end
						end
						if (culled)
							o.vis = VIS_OUTSIDE;
						else if (inside_cnt == depth)
							o.vis = VIS_INSIDE;
						else
							o.vis = VIS_PARTIAL;
						if (it.clear_after)
							mask = FULL_MASK;
					end
				end
				default: begin
				end
			endcase
			o.mask = mask;
			pending.push_back(o);
		endfunction

		function void check_result(cull_outcome_t got);
			cull_outcome_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t: vis %0d acc %0d mask %h",
						$realtime, got.vis, got.acc, got.mask);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  expected vis %0d acc %0d pop %h %h %h %h mask %h",
						exp.vis, exp.acc, exp.pnx, exp.pny, exp.pnz, exp.pd, exp.mask);
					$display("  actual   vis %0d acc %0d pop %h %h %h %h mask %h",
						got.vis, got.acc, got.pnx, got.pny, got.pnz, got.pd, got.mask);
				end
			end
		endfunction
	endclass

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block inputs, all known from time zero
	logic               start        = 1'b0;
	logic [1:0]         action       = '0;
	logic signed [31:0] normal_x     = '0;
	logic signed [31:0] normal_y     = '0;
	logic signed [31:0] normal_z     = '0;
	logic signed [31:0] plane_offset = '0;
	logic signed [31:0] center_x     = '0;
	logic signed [31:0] center_y     = '0;
	logic signed [31:0] center_z     = '0;
	logic [30:0]        radius       = '0;
	logic               clear_after  = 1'b0;

	// block outputs
	logic               busy;
	logic               done;
	logic [1:0]         visibility;
	logic               accepted;
	logic signed [31:0] popped_normal_x;
	logic signed [31:0] popped_normal_y;
	logic signed [31:0] popped_normal_z;
	logic signed [31:0] popped_offset;
	logic [31:0]        active_mask;

	frustum_plane_mask_culler DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.normal_x        (normal_x),
		.normal_y        (normal_y),
		.normal_z        (normal_z),
		.plane_offset    (plane_offset),
		.center_x        (center_x),
		.center_y        (center_y),
		.center_z        (center_z),
		.radius          (radius),
		.clear_after     (clear_after),
		.done            (done),
		.visibility      (visibility),
		.accepted        (accepted),
		.popped_normal_x (popped_normal_x),
		.popped_normal_y (popped_normal_y),
		.popped_normal_z (popped_normal_z),
		.popped_offset   (popped_offset),
		.active_mask     (active_mask)
	);

	culler_scoreboard sb = new();

	int unsigned items_done  = 0;
	int unsigned burst_left  = 0;
	int unsigned idle_cycles = 0;

	// every result strobe is checked against the oldest outcome owed
	always @(posedge clk) begin
		if (done === 1'b1) begin
			sb.check_result('{visibility, accepted, popped_normal_x, popped_normal_y,
				popped_normal_z, popped_offset, active_mask});
		end
	end

	// watchdog: cycles with neither a transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired at %0t", $realtime);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// item builders; unused fields carry random bits so every bit toggles
	function automatic cull_item_t noise_item();
		cull_item_t it;
		it.action      = 2'($urandom_range(0, 3));
		it.nx          = $urandom;
		it.ny          = $urandom;
		it.nz          = $urandom;
		it.d           = $urandom;
		it.cx          = $urandom;
		it.cy          = $urandom;
		it.cz          = $urandom;
		it.radius      = 31'($urandom);
		it.clear_after = 1'($urandom);
		return it;
	endfunction

	function automatic cull_item_t plane_item(logic signed [31:0] nx, logic signed [31:0] ny,
		logic signed [31:0] nz, logic signed [31:0] d);
		cull_item_t it;
		it        = noise_item();
		it.action = ACT_PUSH;
		it.nx     = nx;
		it.ny     = ny;
		it.nz     = nz;
		it.d      = d;
		return it;
	endfunction

	function automatic cull_item_t sphere_item(logic signed [31:0] cx, logic signed [31:0] cy,
		logic signed [31:0] cz, logic [30:0] r, logic clr);
		cull_item_t it;
		it             = noise_item();
		it.action      = ACT_TEST;
		it.cx          = cx;
		it.cy          = cy;
		it.cz          = cz;
		it.radius      = r;
		it.clear_after = clr;
		return it;
	endfunction

	function automatic cull_item_t op_item(logic [1:0] act);
		cull_item_t it;
		it        = noise_item();
		it.action = act;
		return it;
	endfunction

	// near-unit normals and offsets within +-20 units, or any bits at all
	function automatic cull_item_t rand_plane(bit wide);
		if (wide)
			return op_item(ACT_PUSH);
		return plane_item($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
			$urandom_range(0, 131072) - 65536, $urandom_range(0, 40 << 16) - (20 << 16));
	endfunction

	// centers within +-30 units, radius up to 10 units with some points
	function automatic cull_item_t rand_sphere(bit wide);
		logic [30:0] r;
		if (wide)
			return op_item(ACT_TEST);
		r = ($urandom_range(0, 4) == 0) ? 31'd0 : 31'($urandom_range(0, 10 << 16));
		return sphere_item($urandom_range(0, 60 << 16) - (30 << 16),
			$urandom_range(0, 60 << 16) - (30 << 16), $urandom_range(0, 60 << 16) - (30 << 16),
			r, $urandom_range(0, 3) == 0);
	endfunction

	// one transfer; bursts of random length separated by random gaps
	task automatic send(input cull_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		action       <= it.action;
		normal_x     <= it.nx;
		normal_y     <= it.ny;
		normal_z     <= it.nz;
		plane_offset <= it.d;
		center_x     <= it.cx;
		center_y     <= it.cy;
		center_z     <= it.cz;
		radius       <= it.radius;
		clear_after  <= it.clear_after;
		start        <= 1'b1;
		// the transfer happens at the first edge that finds busy low
		do begin
			@(posedge clk);
		end while (busy);
		sb.note_item(it);
		if (it.action != ACT_UNKNOWN)
			items_done++;
	endtask

	// hold off the sender until every owed outcome has arrived
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned seq;
		int unsigned mode;
		seq = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack cases and the ignored action
		send(sphere_item(32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1));
		send(op_item(ACT_POP));
		send(op_item(ACT_UNKNOWN));

		// unit plane x = 0: distance equals x
		send(plane_item(ONE, 32'sd0, 32'sd0, 32'sd0));
		send(sphere_item(32'sd0, S_MAX, S_MIN, 31'd0, 1'b0));        // point on the plane
		send(sphere_item(32'sd196608, 32'sd0, 32'sd0, 31'd196608, 1'b0));  // touching at +r
		send(sphere_item(-32'sd196608, 32'sd0, 32'sd0, 31'd196608, 1'b0)); // touching at -r
		send(sphere_item(-32'sd196609, 32'sd0, 32'sd0, 31'd196608, 1'b0)); // inside, bit cleared
		// masked plane is skipped even though the sphere is far outside
		send(sphere_item(32'sd6553600, 32'sd0, 32'sd0, 31'd0, 1'b1));
		send(sphere_item(32'sd6553600, 32'sd0, 32'sd0, 31'd65536, 1'b0)); // outside
		send(sphere_item(32'sd6553600, 32'sd0, 32'sd0, 31'd65536, 1'b1)); // outside, then clear

		// extreme planes and centers
		send(plane_item(S_MIN, S_MIN, S_MIN, S_MIN));
		send(sphere_item(S_MIN, S_MIN, S_MIN, 31'h7fff_ffff, 1'b0));
		send(plane_item(S_MAX, S_MAX, S_MAX, S_MAX));
		send(sphere_item(S_MAX, S_MAX, S_MAX, 31'd0, 1'b0));
		send(sphere_item(S_MIN, S_MIN, S_MIN, 31'h7fff_ffff, 1'b0));
		send(sphere_item(32'sd0, 32'sd0, 32'sd0, 31'h7fff_ffff, 1'b1));
		send(sphere_item(32'sd0, 32'sd0, 32'sd0, 31'h7fff_ffff, 1'b0));

		// pops return the top plane, the last one is refused
		repeat (4) send(op_item(ACT_POP));
		wait_drained();

		// random sequences, the first one fills the stack and pushes past full
		while (items_done < ITEM_TARGET) begin
			mode = $urandom_range(0, 99);
			if (seq == 0 || mode < 6) begin
				while (sb.depth < MAX_PLANES) send(rand_plane($urandom_range(0, 7) == 0));
				repeat ($urandom_range(1, 2)) send(rand_plane(1'b1));
				repeat ($urandom_range(2, 5)) send(rand_sphere($urandom_range(0, 5) == 0));
				repeat ($urandom_range(0, MAX_PLANES + 1)) send(op_item(ACT_POP));
			end else if (mode < 16) begin
				repeat ($urandom_range(1, 5)) send(noise_item());
			end else begin
				repeat ($urandom_range(0, 4)) send(rand_plane($urandom_range(0, 9) == 0));
				repeat ($urandom_range(1, 6)) send(rand_sphere($urandom_range(0, 9) == 0));
				repeat ($urandom_range(0, 3)) send(op_item(ACT_POP));
			end
			if (seq % 60 == 59)
				wait_drained();
			seq++;
		end

		// drain, then give late or spurious strobes time to show up
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

### frustum_plane_mask_culler.f
rtl/fpmc_pkg.sv
rtl/fpmc_plane_store.sv
rtl/fpmc_mac.sv
rtl/frustum_plane_mask_culler.sv
tb/sv/frustum_plane_mask_culler_tb.sv
